// ===== sv/ejvc_pkg.sv =====
package ejvc_pkg;

    // field widths
    localparam int PIXEL_W      = 13;
    localparam int WIDTH_W      = 12;
    localparam int X_SCALE_W    = 20;
    localparam int Y_SCALE_W    = 24;
    localparam int Y_OFFSET_W   = 24;
    localparam int VALVE_ID_W   = 4;
    localparam int MASK_W       = 9;
    localparam int TRAVEL_W     = 26;

    // configuration port
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 24;
    localparam logic [CFG_INDEX_W-1:0] REG_X_SCALE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_SCALE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET = 2'd2;

    // parameter defaults
    localparam int NOZZLE_COUNT_DEF       = 72;
    localparam int CHANNELS_PER_VALVE_DEF = 9;
    localparam int IMAGE_ROWS_DEF         = 2048;

    // commands per object
    localparam int MAX_RESULTS = 8;

    // fixed point
    localparam int X_FRAC_BITS = 16;
    localparam int Y_FRAC_BITS = 8;
    localparam logic [X_FRAC_BITS-1:0] ROUND_HALF = 16'h8000;
    localparam logic [TRAVEL_W-1:0]    TRAVEL_MAX = '1;

    // empirical nozzle index correction
    localparam int CORR_HIGH_ABOVE = 58;
    localparam int CORR_MID_LO     = 8;
    localparam int CORR_MID_HI     = 13;
    localparam int CORR_LOW_LO     = 2;
    localparam int CORR_LOW_HI     = 6;

    // floor division by the channel count via reciprocal
    localparam int DIV_SHIFT = 16;

endpackage

// ===== sv/ejector_valve_command_gen.sv =====
// Ejector valve command generator.
// Input channel (in_valid/in_ready): one detected object per transaction, centre
// column pixel_x, centre row pixel_y and width object_width. An object at (-1,-1)
// is taken and produces nothing.
// Output channel (out_valid/out_ready): one transaction per touched valve, lowest
// valve first, at most eight per object; last_command marks the final one. When
// no nozzle is touched a single command with valve_id 0 and an empty mask is sent.
// Configuration: x_scale, y_scale, y_offset are written through cfg_wr_en,
// cfg_index, cfg_data with no wait state; write them only while the block is idle.
// The first command of an object passes through five arithmetic stages, the first
// loaded at the accepting edge, and then the command sequencer register.
// Throughput: the output sequencer sends one command per cycle while out_ready is
// high, so an object holds it for one to eight commands; the input side takes one
// object per cycle while the five stages ahead of the sequencer have room.
// When out_ready is low the sequencer holds its command and the stages behind it
// fill up one by one before in_ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and sets the three registers to 0.
module ejector_valve_command_gen #(
    parameter int NOZZLE_COUNT       = ejvc_pkg::NOZZLE_COUNT_DEF,
    parameter int CHANNELS_PER_VALVE = ejvc_pkg::CHANNELS_PER_VALVE_DEF,
    parameter int IMAGE_ROWS         = ejvc_pkg::IMAGE_ROWS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [ejvc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ejvc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ejvc_pkg::PIXEL_W-1:0]    pixel_x,
    input  logic signed [ejvc_pkg::PIXEL_W-1:0]    pixel_y,
    input  logic [ejvc_pkg::WIDTH_W-1:0]           object_width,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [ejvc_pkg::VALVE_ID_W-1:0]        valve_id,
    output logic [ejvc_pkg::MASK_W-1:0]            channel_mask,
    output logic [ejvc_pkg::TRAVEL_W-1:0]          travel_um,
    output logic                                   last_command
);
    import ejvc_pkg::*;

    localparam int VALVE_SLOTS = (NOZZLE_COUNT + CHANNELS_PER_VALVE - 1) / CHANNELS_PER_VALVE;
    localparam int IDX_W  = $clog2(2 * NOZZLE_COUNT + 1);
    localparam int BW     = $clog2(VALVE_SLOTS * CHANNELS_PER_VALVE + 16);
    localparam int VW     = $clog2(VALVE_SLOTS + 1);
    localparam int VIDW   = (VW > VALVE_ID_W) ? VW : VALVE_ID_W;
    localparam int NW     = $clog2(MAX_RESULTS);
    localparam int XPW    = PIXEL_W - 1 + X_SCALE_W;
    localparam int WPW    = WIDTH_W + X_SCALE_W;
    localparam int NXW    = XPW - X_FRAC_BITS + 1;
    localparam int NWW    = WPW - X_FRAC_BITS + 1;
    localparam int DYW    = $clog2(IMAGE_ROWS + 4097);
    localparam int YPW    = DYW + Y_SCALE_W;
    localparam int TSW    = YPW - Y_FRAC_BITS + 1;
    localparam int RW     = DIV_SHIFT + 1;
    localparam logic [RW-1:0] RECIP =
        RW'(((1 << DIV_SHIFT) + CHANNELS_PER_VALVE - 1) / CHANNELS_PER_VALVE);

    // configuration registers
    logic [X_SCALE_W-1:0]  x_scale_reg;
    logic [Y_SCALE_W-1:0]  y_scale_reg;
    logic [Y_OFFSET_W-1:0] y_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg  <= '0;
            y_scale_reg  <= '0;
            y_offset_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_X_SCALE:  x_scale_reg  <= cfg_data[X_SCALE_W-1:0];
                REG_Y_SCALE:  y_scale_reg  <= cfg_data[Y_SCALE_W-1:0];
                REG_Y_OFFSET: y_offset_reg <= cfg_data[Y_OFFSET_W-1:0];
                default:      ;
            endcase
        end
    end

    // pipeline flow control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic seq_valid_reg;
    logic ld1, ld2, ld3, ld4, ld5, seq_load, seq_last;

    assign seq_load = !seq_valid_reg || (out_ready && seq_last);
    assign ld5      = !s5_valid_reg || seq_load;
    assign ld4      = !s4_valid_reg || ld5;
    assign ld3      = !s3_valid_reg || ld4;
    assign ld2      = !s2_valid_reg || ld3;
    assign ld1      = !s1_valid_reg || ld2;
    assign in_ready = ld1;

    // stage 1: the three products
    logic                 no_object;
    logic                 px_pos;
    logic signed [DYW:0]  dy_s;
    logic                 dy_pos;
    logic [XPW-1:0]       s1_prod_x_next, s1_prod_x_reg;
    logic [WPW-1:0]       s1_prod_w_next, s1_prod_w_reg;
    logic [YPW-1:0]       s1_prod_y_next, s1_prod_y_reg;

    always_comb
    begin
        no_object = (&pixel_x) && (&pixel_y);
        px_pos    = !pixel_x[PIXEL_W-1] && (pixel_x != '0);
        dy_s      = $signed((DYW+1)'(IMAGE_ROWS)) - (DYW+1)'(pixel_y);
        dy_pos    = !dy_s[DYW] && (dy_s != '0);
        s1_prod_x_next = px_pos ? XPW'(pixel_x[PIXEL_W-2:0]) * XPW'(x_scale_reg) : '0;
        s1_prod_w_next = WPW'(object_width) * WPW'(x_scale_reg);
        s1_prod_y_next = dy_pos ? YPW'(dy_s[DYW-1:0]) * YPW'(y_scale_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_prod_x_reg <= s1_prod_x_next;
            s1_prod_w_reg <= s1_prod_w_next;
            s1_prod_y_reg <= s1_prod_y_next;
        end
    end

    // stage 2: round, clamp, correct; travel sum with saturation
    logic [XPW:0]         nx_sum;
    logic [WPW:0]         nw_sum;
    logic [NXW-1:0]       nx;
    logic [NWW-1:0]       nw;
    logic [IDX_W-1:0]     idx_clamp;
    logic [IDX_W-1:0]     cnt_clamp;
    logic [IDX_W-1:0]     s2_idx_next, s2_idx_reg;
    logic [IDX_W-1:0]     s2_cnt_next, s2_cnt_reg;
    logic [TSW-1:0]       travel_sum;
    logic [TRAVEL_W-1:0]  s2_travel_next, s2_travel_reg;

    always_comb
    begin
        nx_sum = {1'b0, s1_prod_x_reg} + (XPW+1)'(ROUND_HALF);
        nw_sum = {1'b0, s1_prod_w_reg} + (WPW+1)'(ROUND_HALF);
        nx     = nx_sum[XPW:X_FRAC_BITS];
        nw     = nw_sum[WPW:X_FRAC_BITS];
        idx_clamp = (nx > NXW'(NOZZLE_COUNT - 1)) ? IDX_W'(NOZZLE_COUNT - 1)
                                                  : IDX_W'(nx);
        cnt_clamp = (nw > NWW'(NOZZLE_COUNT - 1)) ? IDX_W'(NOZZLE_COUNT - 1)
                                                  : IDX_W'(nw);
        if (idx_clamp > IDX_W'(CORR_HIGH_ABOVE))
            s2_idx_next = idx_clamp + IDX_W'(1);
        else if (idx_clamp >= IDX_W'(CORR_MID_LO) && idx_clamp <= IDX_W'(CORR_MID_HI))
            s2_idx_next = idx_clamp - IDX_W'(1);
        else if (idx_clamp >= IDX_W'(CORR_LOW_LO) && idx_clamp <= IDX_W'(CORR_LOW_HI))
            s2_idx_next = idx_clamp - IDX_W'(2);
        else
            s2_idx_next = idx_clamp;
        // odd nozzle count goes up to even
        s2_cnt_next = cnt_clamp + IDX_W'(cnt_clamp[0]);
        travel_sum  = TSW'(s1_prod_y_reg >> Y_FRAC_BITS) + TSW'(y_offset_reg);
        s2_travel_next = (travel_sum > TSW'(TRAVEL_MAX)) ? TRAVEL_MAX
                                                         : travel_sum[TRAVEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_idx_reg    <= s2_idx_next;
            s2_cnt_reg    <= s2_cnt_next;
            s2_travel_reg <= s2_travel_next;
        end
    end

    // stage 3: nozzle range, clamped to 1..NOZZLE_COUNT
    logic signed [IDX_W:0] lo_s;
    logic [IDX_W-1:0]      lo_u;
    logic [IDX_W-1:0]      hi_raw;
    logic [IDX_W-1:0]      hi_u;
    logic [BW-1:0]         s3_zlo_next, s3_zlo_reg;
    logic [BW-1:0]         s3_zhi_next, s3_zhi_reg;
    logic                  s3_empty_next, s3_empty_reg;
    logic [TRAVEL_W-1:0]   s3_travel_reg;

    always_comb
    begin
        lo_s   = $signed({1'b0, s2_idx_reg}) - $signed({1'b0, s2_cnt_reg});
        lo_u   = (lo_s < $signed((IDX_W+1)'(1))) ? IDX_W'(1) : lo_s[IDX_W-1:0];
        hi_raw = s2_idx_reg + s2_cnt_reg;
        hi_u   = (hi_raw > IDX_W'(NOZZLE_COUNT)) ? IDX_W'(NOZZLE_COUNT) : hi_raw;
        s3_empty_next = lo_u > hi_u;
        s3_zlo_next   = BW'(lo_u - IDX_W'(1));
        s3_zhi_next   = BW'(hi_u - IDX_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_zlo_reg    <= s3_zlo_next;
            s3_zhi_reg    <= s3_zhi_next;
            s3_empty_reg  <= s3_empty_next;
            s3_travel_reg <= s2_travel_reg;
        end
    end

    // stage 4: first and last valve, floor division by reciprocal
    logic [BW+RW-1:0]     qlo_prod, qhi_prod;
    logic [VW-1:0]        s4_vlo_reg, s4_vhi_reg;
    logic [BW-1:0]        s4_zlo_reg, s4_zhi_reg;
    logic                 s4_empty_reg;
    logic [TRAVEL_W-1:0]  s4_travel_reg;

    always_comb
    begin
        qlo_prod = (BW+RW)'(s3_zlo_reg) * (BW+RW)'(RECIP);
        qhi_prod = (BW+RW)'(s3_zhi_reg) * (BW+RW)'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            s4_vlo_reg    <= VW'(qlo_prod >> DIV_SHIFT);
            s4_vhi_reg    <= VW'(qhi_prod >> DIV_SHIFT);
            s4_zlo_reg    <= s3_zlo_reg;
            s4_zhi_reg    <= s3_zhi_reg;
            s4_empty_reg  <= s3_empty_reg;
            s4_travel_reg <= s3_travel_reg;
        end
    end

    // stage 5: first nozzle of the first valve
    logic [BW-1:0]        s5_base_reg;
    logic [VW-1:0]        s5_vlo_reg, s5_vhi_reg;
    logic [BW-1:0]        s5_zlo_reg, s5_zhi_reg;
    logic                 s5_empty_reg;
    logic [TRAVEL_W-1:0]  s5_travel_reg;

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            s5_base_reg   <= BW'(s4_vlo_reg) * BW'(CHANNELS_PER_VALVE);
            s5_vlo_reg    <= s4_vlo_reg;
            s5_vhi_reg    <= s4_vhi_reg;
            s5_zlo_reg    <= s4_zlo_reg;
            s5_zhi_reg    <= s4_zhi_reg;
            s5_empty_reg  <= s4_empty_reg;
            s5_travel_reg <= s4_travel_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            seq_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                s1_valid_reg <= in_valid && !no_object;
            if (ld2)
                s2_valid_reg <= s1_valid_reg;
            if (ld3)
                s3_valid_reg <= s2_valid_reg;
            if (ld4)
                s4_valid_reg <= s3_valid_reg;
            if (ld5)
                s5_valid_reg <= s4_valid_reg;
            if (seq_load)
                seq_valid_reg <= s5_valid_reg;
        end
    end

    // command sequencer: walks the touched valves, one per output transaction
    logic [VW-1:0]        valve_reg, valve_next;
    logic [VW-1:0]        vhi_reg;
    logic [BW-1:0]        base_reg, base_next;
    logic [BW-1:0]        zlo_reg, zhi_reg;
    logic [NW-1:0]        num_reg, num_next;
    logic                 empty_reg;
    logic [TRAVEL_W-1:0]  travel_reg;
    logic [VIDW-1:0]      vid_full;
    logic [BW-1:0]        nozzle;
    logic [MASK_W-1:0]    mask;

    assign seq_last = empty_reg || (valve_reg == vhi_reg) || (num_reg == NW'(MAX_RESULTS - 1));

    always_comb
    begin
        valve_next = valve_reg + VW'(1);
        base_next  = base_reg + BW'(CHANNELS_PER_VALVE);
        num_next   = num_reg + NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (seq_load)
        begin
            valve_reg  <= s5_vlo_reg;
            vhi_reg    <= s5_vhi_reg;
            base_reg   <= s5_base_reg;
            zlo_reg    <= s5_zlo_reg;
            zhi_reg    <= s5_zhi_reg;
            num_reg    <= '0;
            empty_reg  <= s5_empty_reg;
            travel_reg <= s5_travel_reg;
        end
        else if (out_ready)
        begin
            valve_reg <= valve_next;
            base_reg  <= base_next;
            num_reg   <= num_next;
        end
    end

    always_comb
    begin
        nozzle = '0;
        mask   = '0;
        for (int k = 0; k < MASK_W; k++)
        begin
            nozzle = base_reg + BW'(k);
            mask[k] = (k < CHANNELS_PER_VALVE) && !empty_reg
                      && (nozzle >= zlo_reg) && (nozzle <= zhi_reg);
        end
        vid_full = VIDW'(valve_reg) + VIDW'(1);
    end

    assign out_valid    = seq_valid_reg;
    assign valve_id     = empty_reg ? '0 : vid_full[VALVE_ID_W-1:0];
    assign channel_mask = mask;
    assign travel_um    = travel_reg;
    assign last_command = seq_last;

endmodule

// ===== sv/ejvc_checker.sv =====
module ejvc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [ejvc_pkg::VALVE_ID_W-1:0]   valve_id,
    input logic [ejvc_pkg::MASK_W-1:0]       channel_mask,
    input logic [ejvc_pkg::TRAVEL_W-1:0]     travel_um,
    input logic                              last_command
);
    import ejvc_pkg::*;

    // tracks whether the next command continues the same object
    logic                  cont_reg, cont_next;
    logic [VALVE_ID_W-1:0] prev_id_reg, prev_id_next;

    always_comb
    begin
        cont_next    = cont_reg;
        prev_id_next = prev_id_reg;
        if (out_valid && out_ready)
        begin
            cont_next    = !last_command;
            prev_id_next = valve_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_reg    <= 1'b0;
            prev_id_reg <= '0;
        end
        else
        begin
            cont_reg    <= cont_next;
            prev_id_reg <= prev_id_next;
        end
    end

    // a stalled command holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valve_id)
            && $stable(channel_mask) && $stable(travel_um) && $stable(last_command))
        else $error("output command changed while stalled");

    // the no-nozzle command is a lone, empty one
    a_empty_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valve_id == '0 |-> channel_mask == '0 && last_command)
        else $error("valve 0 command with mask or without last");

    // commands of one object cover consecutive valves
    a_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cont_reg |-> valve_id == prev_id_reg + VALVE_ID_W'(1))
        else $error("valve sequence not consecutive");

    // nothing is offered in the first cycle after reset
    a_reset_idle: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind ejector_valve_command_gen ejvc_checker u_ejvc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .valve_id     (valve_id),
    .channel_mask (channel_mask),
    .travel_um    (travel_um),
    .last_command (last_command)
);

// ===== tb/ejector_valve_command_gen_tb.sv =====
`timescale 1ns / 100ps

module ejector_valve_command_gen_tb;

    import ejvc_pkg::*;

    localparam int NOZZLES        = NOZZLE_COUNT_DEF;
    localparam int CHANNELS       = CHANNELS_PER_VALVE_DEF;
    localparam int ROWS           = IMAGE_ROWS_DEF;
    localparam int VALVES         = (NOZZLES + CHANNELS - 1) / CHANNELS;
    localparam logic [VALVE_ID_W-1:0] NO_VALVE = '0;
    localparam int SETTLE_CYCLES  = 12;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_OFF_LEN   = 60;

    typedef struct packed {
        logic [VALVE_ID_W-1:0] valve_id;
        logic [MASK_W-1:0]     mask;
        logic [TRAVEL_W-1:0]   travel;
        logic                  is_last;
    } valve_cmd_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0]       cfg_index    = '0;
    logic [CFG_DATA_W-1:0]        cfg_data     = '0;
    logic                         in_valid     = 1'b0;
    logic                         in_ready;
    logic signed [PIXEL_W-1:0]    pixel_x      = '0;
    logic signed [PIXEL_W-1:0]    pixel_y      = '0;
    logic [WIDTH_W-1:0]           object_width = '0;
    logic                         out_valid;
    logic                         out_ready    = 1'b0;
    logic [VALVE_ID_W-1:0]        valve_id;
    logic [MASK_W-1:0]            channel_mask;
    logic [TRAVEL_W-1:0]          travel_um;
    logic                         last_command;

    // scale registers as the block should hold them
    logic [X_SCALE_W-1:0]  x_scale_q  = '0;
    logic [Y_SCALE_W-1:0]  y_scale_q  = '0;
    logic [Y_OFFSET_W-1:0] y_offset_q = '0;

    valve_cmd_t cmds_due[$];
    valve_cmd_t head_cmd;

    int  n_objects     = 0;
    int  n_empty_items = 0;
    int  n_commands    = 0;
    int  n_reg_writes  = 0;
    int  n_errors      = 0;
    int  idle_cycles   = 0;
    int  hold_off_left = 0;
    int  ready_gap     = 0;
    bit  no_idle       = 1'b0;

    ejector_valve_command_gen u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .object_width (object_width),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valve_id     (valve_id),
        .channel_mask (channel_mask),
        .travel_um    (travel_um),
        .last_command (last_command)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int nozzle_of(input int pix);
        longint unsigned prod;
        if (pix <= 0)
            return 0;
        prod = (longint'(pix) * x_scale_q + ROUND_HALF) >> X_FRAC_BITS;
        if (prod > NOZZLES - 1)
            return NOZZLES - 1;
        return int'(prod);
    endfunction

    task automatic derive_valve_cmds(input logic signed [PIXEL_W-1:0] px,
                                     input logic signed [PIXEL_W-1:0] py,
                                     input logic [WIDTH_W-1:0] w);
        int idx, cnt, lo, hi, dy, last_v;
        longint unsigned travel, dyu;
        logic [MASK_W-1:0] masks [VALVES];
        valve_cmd_t cmd;
        if (px == -1 && py == -1)
            return;

        dy = ROWS - int'(py);
        dyu = (dy > 0) ? 64'(dy) : 64'd0;
        travel = (dyu * y_scale_q) >> Y_FRAC_BITS;
        travel = travel + y_offset_q;
        if (travel > TRAVEL_MAX)
            travel = TRAVEL_MAX;

        idx = nozzle_of(int'(px));
        if (idx > CORR_HIGH_ABOVE)
            idx = idx + 1;
        else if (idx >= CORR_MID_LO && idx <= CORR_MID_HI)
            idx = idx - 1;
        else if (idx >= CORR_LOW_LO && idx <= CORR_LOW_HI)
            idx = idx - 2;

        cnt = nozzle_of(int'(w));
        if (cnt % 2 != 0)
            cnt = cnt + 1;

        lo = (idx - cnt < 1) ? 1 : idx - cnt;
        hi = (idx + cnt > NOZZLES) ? NOZZLES : idx + cnt;

        for (int v = 0; v < VALVES; v++)
            masks[v] = '0;
        for (int i = lo; i <= hi; i++)
            masks[(i - 1) / CHANNELS][(i - 1) % CHANNELS] = 1'b1;

        last_v = -1;
        for (int v = 0; v < VALVES; v++)
            if (masks[v] != '0)
                last_v = v;

        cmd.travel = travel[TRAVEL_W-1:0];
        if (last_v < 0)
        begin
            cmd.valve_id = NO_VALVE;
            cmd.mask     = '0;
            cmd.is_last  = 1'b1;
            cmds_due = {cmds_due, cmd};
        end
        else
        begin
            for (int v = 0; v <= last_v; v++)
            begin
                if (masks[v] != '0)
                begin
                    cmd.valve_id = VALVE_ID_W'(v + 1);
                    cmd.mask     = masks[v];
                    cmd.is_last  = (v == last_v);
                    cmds_due = {cmds_due, cmd};
                end
            end
        end
    endtask

    task automatic send_object(input int px, input int py, input int w);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        pixel_x      = PIXEL_W'(px);
        pixel_y      = PIXEL_W'(py);
        object_width = WIDTH_W'(w);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        derive_valve_cmds(pixel_x, pixel_y, object_width);
        n_objects++;
        if (pixel_x == -1 && pixel_y == -1)
            n_empty_items++;
    endtask

    task automatic send_random_object();
        int px, py, w;
        case ($urandom_range(0, 9))
            0:
            begin
                px = -1;
                py = -1;
                w  = int'($urandom_range(0, 4095));
            end
            1:
            begin
                px = int'($urandom_range(0, 8191)) - 4096;
                py = int'($urandom_range(0, 8191)) - 4096;
                w  = int'($urandom_range(0, 4095));
            end
            default:
            begin
                px = int'($urandom_range(0, 4095));
                py = int'($urandom_range(0, 2049)) - 1;
                w  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4095))
                                                 : int'($urandom_range(0, 300));
            end
        endcase
        send_object(px, py, w);
    endtask

    // lower valid, then wait until every command has come out and the pipe is empty
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (cmds_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            REG_X_SCALE:  x_scale_q  = data[X_SCALE_W-1:0];
            REG_Y_SCALE:  y_scale_q  = data[Y_SCALE_W-1:0];
            REG_Y_OFFSET: y_offset_q = data[Y_OFFSET_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_scales(input logic [X_SCALE_W-1:0] xs,
                                input logic [Y_SCALE_W-1:0] ys,
                                input logic [Y_OFFSET_W-1:0] yo);
        wait_idle();
        write_reg(REG_X_SCALE, CFG_DATA_W'(xs));
        write_reg(REG_Y_SCALE, CFG_DATA_W'(ys));
        write_reg(REG_Y_OFFSET, CFG_DATA_W'(yo));
    endtask

    // unit x scale so the column is the nozzle index directly
    task automatic test_directed_geometry();
        apply_scales(20'd65536, 24'd256, 24'd1000);
        send_object(-1, -1, 0);
        send_object(-1, -1, 4095);
        send_object(-1, 100, 2);
        send_object(0, -1, 5);
        send_object(-4096, -4096, 0);
        send_object(4095, 4095, 4095);
        send_object(0, 2048, 0);
        send_object(59, 0, 0);
        send_object(58, 1000, 0);
        send_object(8, 10, 0);
        send_object(13, 10, 0);
        send_object(14, 10, 0);
        send_object(7, 10, 0);
        send_object(2, 10, 0);
        send_object(6, 10, 0);
        send_object(1, 10, 0);
        send_object(20, 2047, 1);
        send_object(71, 2049, 0);
        send_object(36, 500, 3);
        send_object(40, 2048, 2048);
    endtask

    task automatic test_register_extremes();
        // saturated travel, clamped index and count
        apply_scales('1, '1, '1);
        send_object(1, 0, 1);
        send_object(4095, -4096, 0);
        send_object(2, 2048, 0);
        // half a nozzle per pixel exercises round half up
        apply_scales(20'd32768, 24'd1, 24'd0);
        send_object(1, 2047, 1);
        send_object(3, 0, 3);
        // zero scales: everything lands at index 0, nothing touched
        apply_scales('0, '0, '0);
        send_object(4095, 0, 4095);
        send_object(100, 2048, 7);
    endtask

    task automatic test_random_objects();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: apply_scales(X_SCALE_W'($urandom_range(1000, 1400)),
                                Y_SCALE_W'($urandom_range(0, 4000)),
                                Y_OFFSET_W'($urandom_range(0, 200000)));
                1: apply_scales(X_SCALE_W'($urandom), Y_SCALE_W'($urandom),
                                Y_OFFSET_W'($urandom));
                2: apply_scales(X_SCALE_W'($urandom_range(4000, 70000)),
                                Y_SCALE_W'($urandom_range(100, 1000)),
                                Y_OFFSET_W'($urandom_range(0, 5000)));
                default: apply_scales(X_SCALE_W'($urandom_range(600, 2000)),
                                      Y_SCALE_W'($urandom), Y_OFFSET_W'($urandom));
            endcase
            repeat (12) send_random_object();
        end
    endtask

    // receiver stalls long while objects keep coming, so in_ready has to drop
    task automatic test_output_hold_off();
        apply_scales(X_SCALE_W'($urandom_range(1000, 1400)),
                     Y_SCALE_W'($urandom_range(100, 3000)),
                     Y_OFFSET_W'($urandom_range(0, 100000)));
        no_idle = 1'b1;
        hold_off_left = HOLD_OFF_LEN;
        repeat (12) send_random_object();
        no_idle = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (5) send_random_object();
        wait_idle();
        repeat (5) send_random_object();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (12) send_random_object();
        no_idle = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready = 1'b0;
        else if (hold_off_left > 0)
        begin
            out_ready = 1'b0;
            hold_off_left--;
        end
        else if (ready_gap > 0)
        begin
            out_ready = 1'b0;
            ready_gap--;
        end
        else
        begin
            out_ready = 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                ready_gap = pick_gap();
        end
    end

    task automatic report_mismatch(input string field, input logic [TRAVEL_W-1:0] want,
                                   input logic [TRAVEL_W-1:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        n_errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_commands++;
            if (cmds_due.size() == 0)
            begin
                $display("%0t: unexpected transaction valve_id=%0h mask=%0h travel=%0h last=%0b",
                         $time, valve_id, channel_mask, travel_um, last_command);
                n_errors++;
            end
            else
            begin
                head_cmd = cmds_due.pop_front();
                if (valve_id !== head_cmd.valve_id)
                    report_mismatch("valve_id", TRAVEL_W'(head_cmd.valve_id),
                                    TRAVEL_W'(valve_id));
                if (channel_mask !== head_cmd.mask)
                    report_mismatch("channel_mask", TRAVEL_W'(head_cmd.mask),
                                    TRAVEL_W'(channel_mask));
                if (travel_um !== head_cmd.travel)
                    report_mismatch("travel_um", head_cmd.travel, travel_um);
                if (last_command !== head_cmd.is_last)
                    report_mismatch("last_command", TRAVEL_W'(head_cmd.is_last),
                                    TRAVEL_W'(last_command));
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d commands still due",
                     $time, STALL_LIMIT, cmds_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_geometry();
        test_register_extremes();
        test_random_objects();
        test_output_hold_off();
        test_sender_pause();
        test_back_to_back();
        wait_idle();

        if (cmds_due.size() != 0)
        begin
            $display("%0t: %0d commands never arrived", $time, cmds_due.size());
            n_errors += cmds_due.size();
        end
        $display("objects sent: %0d (%0d with no object), valve commands checked: %0d",
                 n_objects, n_empty_items, n_commands);
        $display("register writes: %0d, scale settings incl. zero and full scale, %0d errors",
                 n_reg_writes, n_errors);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== ejector_valve_command_gen.f =====
sv/ejvc_pkg.sv
sv/ejector_valve_command_gen.sv
sv/ejvc_checker.sv
tb/ejector_valve_command_gen_tb.sv
